// File: sv/arbt_pkg.sv
// ----------------------------------------------------------------------------
// arbt_pkg
// Shared types and constants of the angular region boundary table.
// ----------------------------------------------------------------------------
package arbt_pkg;

   localparam int MaxRegionsDefault = 16;

   typedef logic [15:0] angle_type;

   typedef enum logic [1:0] {
      CmdSplit  = 2'd0,
      CmdModify = 2'd1,
      CmdRemove = 2'd2,
      CmdLookup = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CsrMinAngle = 2'd0,
      CsrMaxAngle = 2'd1,
      CsrMinWidth = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      SclIdle,
      SclMul,
      SclDiv,
      SclFix
   } scl_state_type;

   // base + floor(sign_n * fa * fb / (sign_d * dm)), clamped to 16 bits
   typedef struct packed {
      angle_type fa;
      angle_type fb;
      logic      neg_n;
      angle_type dm;
      logic      neg_d;
      angle_type base;
   } scl_req_type;

   typedef enum logic [4:0] {
      StIdle,
      StSplGo,
      StSplWait,
      StLk0,
      StLk1,
      StLk2,
      StMsChk,
      StMsA,
      StMsB,
      StMsC,
      StMsSg,
      StMsSs,
      StMsSw,
      StMeChk,
      StMeA,
      StMeB,
      StMeC,
      StMeSg,
      StMeSs,
      StMeSw,
      StClChk,
      StClA,
      StClB,
      StRmChk,
      StRmM1,
      StRmM2,
      StRmSh,
      StRmShw,
      StDone
   } seq_state_type;

endpackage

// File: sv/angular_region_boundary_table_unit.sv
// ----------------------------------------------------------------------------
// angular_region_boundary_table_unit
// Ordered boundary table splitting [min_angle, max_angle) into regions.
// ----------------------------------------------------------------------------
// Commands arrive on the req_ channel (valid/ready) and each gives exactly one
// transaction on the rsp_ channel. The block works on one command at a time:
// req_ready is high only while the sequencer is idle. Work per command:
//   even split      one scaler pass per boundary
//   lookup          reads the boundaries of each region tested
//   remove          shifts the later boundaries down by one slot
//   modify          one scaler pass per rescaled boundary, plus cleanup, which
//                   reads two boundaries per region and may remove several
// The shared scaler (multiply, 32-step divide, clamp) and the single read port
// of the boundary memory pace this work. A result waits in the output
// register while rsp_ready is low; the next command may already be taken, but
// its result is held back until the earlier one is gone.
// csr_ writes set min_angle, max_angle and min_width and are meant to come only
// while the block is idle. Reset empties the table (no regions) and restores
// the register defaults; boundaries hold no value until an even split.
// ----------------------------------------------------------------------------
module angular_region_boundary_table_unit #(
   parameter int REGION_LIMIT = arbt_pkg::MaxRegionsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [3:0]           req_region,
   input  arbt_pkg::angle_type  req_first_angle,
   input  arbt_pkg::angle_type  req_second_angle,
   input  logic                 req_method,
   input  logic [4:0]           req_count,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_ok,
   output logic                 rsp_found,
   output logic [3:0]           rsp_region_index,
   output logic [4:0]           rsp_region_count,
   output arbt_pkg::angle_type  rsp_region_start,
   output arbt_pkg::angle_type  rsp_region_end,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  arbt_pkg::angle_type  csr_wdata
);
   import arbt_pkg::*;

   localparam int AW = $clog2(REGION_LIMIT + 1);
   localparam int IW = ((AW > 4) ? AW : 4) + 2;

   // configuration
   angle_type min_ff, max_ff, minw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '0;
         max_ff  <= '1;
         minw_ff <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CsrMinAngle: min_ff  <= csr_wdata;
            CsrMaxAngle: max_ff  <= csr_wdata;
            CsrMinWidth: minw_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // boundary memory
   angle_type       bnd_mem [REGION_LIMIT+1];
   angle_type       rd_q_ff;
   logic [AW-1:0]   rd_addr;
   logic            mem_we;
   logic [AW-1:0]   mem_wa;
   angle_type       mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bnd_mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= bnd_mem[rd_addr];
   end

   // shared scaler
   logic        scl_start;
   scl_req_type scl_req;
   logic        scl_done;
   angle_type   scl_result;

   arbt_scaler u_scaler (
      .clock  (clock),
      .reset  (reset),
      .start  (scl_start),
      .req    (scl_req),
      .done   (scl_done),
      .result (scl_result)
   );

   // sequencer state
   seq_state_type state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [3:0]    region_ff, region_in;
   angle_type     a1_ff, a1_in;
   angle_type     a2_ff, a2_in;
   logic          method_ff, method_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] active_ff, active_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] jj_ff, jj_in;
   logic [IW-1:0] rr_ff, rr_in;
   angle_type     lo_ff, lo_in;
   angle_type     old_ff, old_in;
   logic          ok_ff, ok_in;
   logic          found_ff, found_in;
   logic [3:0]    fidx_ff, fidx_in;
   angle_type     rs_ff, rs_in;
   angle_type     re_ff, re_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [3:0]    rsp_idx_ff, rsp_idx_in;
   logic [4:0]    rsp_cnt_ff, rsp_cnt_in;
   angle_type     rsp_rs_ff, rsp_rs_in;
   angle_type     rsp_re_ff, rsp_re_in;

   logic [IW-1:0]      act_w;
   logic [IW-1:0]      reg_w;
   logic [IW-1:0]      req_cnt_w;
   angle_type          span;
   logic signed [16:0] width_s;
   logic [16:0]        mid_sum;
   logic               rm_ok;
   logic               rm_ret;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      region_in    = region_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      method_in    = method_ff;
      cnt_in       = cnt_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      jj_in        = jj_ff;
      rr_in        = rr_ff;
      lo_in        = lo_ff;
      old_in       = old_ff;
      ok_in        = ok_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      rs_in        = rs_ff;
      re_in        = re_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_found_in = rsp_found_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_rs_in    = rsp_rs_ff;
      rsp_re_in    = rsp_re_ff;
      req_ready    = 1'b0;
      rd_addr      = '0;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      scl_start    = 1'b0;
      scl_req      = '0;
      rm_ok        = 1'b0;
      rm_ret       = 1'b0;

      act_w     = IW'(active_ff);
      reg_w     = IW'(region_ff);
      req_cnt_w = IW'(req_count);
      span      = (max_ff > min_ff) ? (max_ff - min_ff) : '0;
      width_s   = $signed({1'b0, rd_q_ff}) - $signed({1'b0, lo_ff});
      mid_sum   = {1'b0, lo_ff} + {1'b0, rd_q_ff};

      unique case (state_ff)
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in    = cmd_type'(req_cmd);
               region_in = req_region;
               a1_in     = req_first_angle;
               a2_in     = req_second_angle;
               method_in = req_method;
               cnt_in    = (req_cnt_w > IW'(REGION_LIMIT)) ? IW'(REGION_LIMIT) : req_cnt_w;
               ok_in     = 1'b0;
               found_in  = 1'b0;
               fidx_in   = '0;
               rs_in     = '0;
               re_in     = '0;
               idx_in    = '0;
               unique case (cmd_type'(req_cmd))
                  CmdSplit: begin
                     state_in = (req_count == '0) ? StDone : StSplGo;
                  end
                  CmdModify: begin
                     state_in = StMsChk;
                  end
                  CmdRemove: begin
                     rr_in    = IW'(req_region);
                     state_in = StRmChk;
                  end
                  CmdLookup: begin
                     state_in = (active_ff == '0) ? StDone : StLk0;
                  end
                  default: begin
                     state_in = StDone;
                  end
               endcase
            end
         end

         // even split: boundary i = min + floor(i * span / count)
         StSplGo: begin
            scl_start     = 1'b1;
            scl_req.fa    = 16'(idx_ff);
            scl_req.fb    = span;
            scl_req.neg_n = 1'b0;
            scl_req.dm    = 16'(cnt_ff);
            scl_req.neg_d = 1'b0;
            scl_req.base  = min_ff;
            state_in      = StSplWait;
         end
         StSplWait: begin
            if (scl_done) begin
               mem_we = 1'b1;
               mem_wa = AW'(idx_ff);
               mem_wd = scl_result;
               if (idx_ff == cnt_ff) begin
                  active_in = AW'(cnt_ff);
                  ok_in     = 1'b1;
                  state_in  = StDone;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = StSplGo;
               end
            end
         end

         // lookup
         StLk0: begin
            rd_addr  = '0;
            state_in = StLk1;
         end
         StLk1: begin
            lo_in    = rd_q_ff;
            rd_addr  = AW'(idx_ff + IW'(1));
            state_in = StLk2;
         end
         StLk2: begin
            if ((a1_ff >= lo_ff) && (a1_ff < rd_q_ff)) begin
               found_in = 1'b1;
               ok_in    = 1'b1;
               fidx_in  = 4'(idx_ff);
               rs_in    = lo_ff;
               re_in    = rd_q_ff;
               state_in = StDone;
            end else if ((idx_ff + IW'(1)) == act_w) begin
               state_in = StDone;
            end else begin
               idx_in  = idx_ff + IW'(1);
               lo_in   = rd_q_ff;
               rd_addr = AW'(idx_ff + IW'(2));
            end
         end

         // modify: start edge
         StMsChk: begin
            if ((region_ff == '0) || (reg_w >= act_w)) begin
               state_in = StMeChk;
            end else begin
               rd_addr  = AW'(reg_w);
               state_in = StMsA;
            end
         end
         StMsA: begin
            old_in   = rd_q_ff;
            rd_addr  = AW'(reg_w + IW'(1));
            state_in = StMsB;
         end
         StMsB: begin
            if (a1_ff == old_ff) begin
               ok_in    = 1'b1;
               state_in = StMeChk;
            end else if (a1_ff >= rd_q_ff) begin
               state_in = StMeChk;
            end else if ((a1_ff < min_ff) || (a1_ff > max_ff)) begin
               state_in = StMeChk;
            end else if (!method_ff) begin
               rd_addr  = AW'(reg_w - IW'(1));
               state_in = StMsC;
            end else begin
               mem_we = 1'b1;
               mem_wa = AW'(reg_w);
               mem_wd = a1_ff;
               ok_in  = 1'b1;
               if ((reg_w <= IW'(1)) || (old_ff == min_ff)) begin
                  state_in = StMeChk;
               end else begin
                  jj_in    = reg_w - IW'(1);
                  state_in = StMsSg;
               end
            end
         end
         StMsC: begin
            if (a1_ff > rd_q_ff) begin
               mem_we = 1'b1;
               mem_wa = AW'(reg_w);
               mem_wd = a1_ff;
               ok_in  = 1'b1;
            end
            state_in = StMeChk;
         end
         StMsSg: begin
            rd_addr  = AW'(jj_ff);
            state_in = StMsSs;
         end
         StMsSs: begin
            scl_start     = 1'b1;
            scl_req.fa    = a1_ff - min_ff;
            scl_req.fb    = (rd_q_ff >= min_ff) ? (rd_q_ff - min_ff) : (min_ff - rd_q_ff);
            scl_req.neg_n = rd_q_ff < min_ff;
            scl_req.dm    = (old_ff >= min_ff) ? (old_ff - min_ff) : (min_ff - old_ff);
            scl_req.neg_d = old_ff < min_ff;
            scl_req.base  = min_ff;
            state_in      = StMsSw;
         end
         StMsSw: begin
            if (scl_done) begin
               mem_we = 1'b1;
               mem_wa = AW'(jj_ff);
               mem_wd = scl_result;
               if (jj_ff == IW'(1)) begin
                  state_in = StMeChk;
               end else begin
                  jj_in    = jj_ff - IW'(1);
                  state_in = StMsSg;
               end
            end
         end

         // modify: end edge
         StMeChk: begin
            idx_in = '0;
            if ((reg_w >= act_w) || ((reg_w + IW'(1)) >= act_w)) begin
               state_in = StClChk;
            end else begin
               rd_addr  = AW'(reg_w + IW'(1));
               state_in = StMeA;
            end
         end
         StMeA: begin
            old_in   = rd_q_ff;
            rd_addr  = AW'(reg_w);
            state_in = StMeB;
         end
         StMeB: begin
            if (a2_ff == old_ff) begin
               ok_in    = 1'b1;
               state_in = StClChk;
            end else if (a2_ff < rd_q_ff) begin
               state_in = StClChk;
            end else if ((a2_ff < min_ff) || (a2_ff > max_ff)) begin
               state_in = StClChk;
            end else if (!method_ff) begin
               rd_addr  = AW'(reg_w + IW'(2));
               state_in = StMeC;
            end else begin
               mem_we = 1'b1;
               mem_wa = AW'(reg_w + IW'(1));
               mem_wd = a2_ff;
               ok_in  = 1'b1;
               if (((reg_w + IW'(2)) >= act_w) || (old_ff == max_ff)) begin
                  state_in = StClChk;
               end else begin
                  jj_in    = reg_w + IW'(2);
                  state_in = StMeSg;
               end
            end
         end
         StMeC: begin
            if (a2_ff <= rd_q_ff) begin
               mem_we = 1'b1;
               mem_wa = AW'(reg_w + IW'(1));
               mem_wd = a2_ff;
               ok_in  = 1'b1;
            end
            state_in = StClChk;
         end
         StMeSg: begin
            rd_addr  = AW'(jj_ff);
            state_in = StMeSs;
         end
         StMeSs: begin
            // max - ceil(num / den) written as max + floor(-num / den)
            scl_start     = 1'b1;
            scl_req.fa    = max_ff - a2_ff;
            scl_req.fb    = (rd_q_ff <= max_ff) ? (max_ff - rd_q_ff) : (rd_q_ff - max_ff);
            scl_req.neg_n = !(rd_q_ff > max_ff);
            scl_req.dm    = (old_ff <= max_ff) ? (max_ff - old_ff) : (old_ff - max_ff);
            scl_req.neg_d = old_ff > max_ff;
            scl_req.base  = max_ff;
            state_in      = StMeSw;
         end
         StMeSw: begin
            if (scl_done) begin
               mem_we = 1'b1;
               mem_wa = AW'(jj_ff);
               mem_wd = scl_result;
               if ((jj_ff + IW'(1)) == act_w) begin
                  state_in = StClChk;
               end else begin
                  jj_in    = jj_ff + IW'(1);
                  state_in = StMeSg;
               end
            end
         end

         // cleanup of narrow regions, left to right
         StClChk: begin
            if (idx_ff >= act_w) begin
               state_in = StDone;
            end else begin
               rd_addr  = AW'(idx_ff);
               state_in = StClA;
            end
         end
         StClA: begin
            lo_in    = rd_q_ff;
            rd_addr  = AW'(idx_ff + IW'(1));
            state_in = StClB;
         end
         StClB: begin
            if (width_s < $signed({1'b0, minw_ff})) begin
               rr_in    = idx_ff;
               state_in = StRmChk;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = StClChk;
            end
         end

         // region removal, shared by remove and cleanup
         StRmChk: begin
            if ((act_w <= IW'(1)) || (rr_ff >= act_w)) begin
               rm_ret = 1'b1;
               rm_ok  = 1'b0;
            end else if (rr_ff == '0) begin
               jj_in    = IW'(1);
               state_in = StRmSh;
            end else if (rr_ff == (act_w - IW'(1))) begin
               jj_in    = rr_ff;
               state_in = StRmSh;
            end else begin
               rd_addr  = AW'(rr_ff);
               state_in = StRmM1;
            end
         end
         StRmM1: begin
            lo_in    = rd_q_ff;
            rd_addr  = AW'(rr_ff + IW'(1));
            state_in = StRmM2;
         end
         StRmM2: begin
            mem_we   = 1'b1;
            mem_wa   = AW'(rr_ff);
            mem_wd   = mid_sum[16:1];
            jj_in    = rr_ff + IW'(1);
            state_in = StRmSh;
         end
         StRmSh: begin
            if (jj_ff < act_w) begin
               rd_addr  = AW'(jj_ff + IW'(1));
               state_in = StRmShw;
            end else begin
               active_in = active_ff - AW'(1);
               rm_ret    = 1'b1;
               rm_ok     = 1'b1;
            end
         end
         StRmShw: begin
            mem_we   = 1'b1;
            mem_wa   = AW'(jj_ff);
            mem_wd   = rd_q_ff;
            jj_in    = jj_ff + IW'(1);
            state_in = StRmSh;
         end

         StDone: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_found_in = found_ff;
               rsp_idx_in   = fidx_ff;
               rsp_cnt_in   = 5'(active_ff);
               rsp_rs_in    = rs_ff;
               rsp_re_in    = re_ff;
               state_in     = StIdle;
            end
         end

         default: begin
            state_in = StIdle;
         end
      endcase

      // return from removal
      if (rm_ret) begin
         if (cmd_ff == CmdRemove) begin
            ok_in    = rm_ok;
            state_in = StDone;
         end else begin
            if (!rm_ok) begin
               idx_in = idx_ff + IW'(1);
            end
            state_in = StClChk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      region_ff    <= region_in;
      a1_ff        <= a1_in;
      a2_ff        <= a2_in;
      method_ff    <= method_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      jj_ff        <= jj_in;
      rr_ff        <= rr_in;
      lo_ff        <= lo_in;
      old_ff       <= old_in;
      ok_ff        <= ok_in;
      found_ff     <= found_in;
      fidx_ff      <= fidx_in;
      rs_ff        <= rs_in;
      re_ff        <= re_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_rs_ff    <= rsp_rs_in;
      rsp_re_ff    <= rsp_re_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_region_index = rsp_idx_ff;
   assign rsp_region_count = rsp_cnt_ff;
   assign rsp_region_start = rsp_rs_ff;
   assign rsp_region_end   = rsp_re_ff;

   // a taken command makes req_ready drop in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready did not drop after a command was taken");

   // the scaler only finishes while the sequencer is waiting for it
   assert property (@(posedge clock) disable iff (reset)
      scl_done |-> (state_ff == StSplWait || state_ff == StMsSw || state_ff == StMeSw))
      else $error("scaler result arrived outside a wait state");

   // a new result only appears after the completion state
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(state_ff == StDone))
      else $error("result raised without passing through completion");

   // a found region is never empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_rs_ff < rsp_re_ff))
      else $error("found region has start not below end");

endmodule

// File: sv/arbt_scaler.sv
// ----------------------------------------------------------------------------
// arbt_scaler
// Shared scaling unit: one 16x16 multiply, a radix-2 restoring divide of the
// 32-bit product, then floor correction, offset and clamp.
// ----------------------------------------------------------------------------
module arbt_scaler (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  arbt_pkg::scl_req_type  req,
   output logic                   done,
   output arbt_pkg::angle_type    result
);
   import arbt_pkg::*;

   scl_state_type state_ff, state_in;
   angle_type     a_ff, a_in;
   angle_type     b_ff, b_in;
   angle_type     d_ff, d_in;
   angle_type     base_ff, base_in;
   logic          neg_ff, neg_in;
   logic [31:0]   quot_ff, quot_in;
   logic [15:0]   rem_ff, rem_in;
   logic [4:0]    cnt_ff, cnt_in;

   logic [16:0]        rem_sh;
   logic [16:0]        diff;
   logic [32:0]        qmag;
   logic signed [34:0] sum;

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      base_in  = base_ff;
      neg_in   = neg_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      result   = '0;
      rem_sh   = {rem_ff, quot_ff[31]};
      diff     = rem_sh - {1'b0, d_ff};
      qmag     = {1'b0, quot_ff} + 33'((neg_ff && (rem_ff != '0)) ? 1 : 0);
      sum      = neg_ff ? ($signed({19'd0, base_ff}) - $signed({2'd0, qmag}))
                        : ($signed({19'd0, base_ff}) + $signed({2'd0, qmag}));
      unique case (state_ff)
         SclIdle: begin
            if (start) begin
               a_in     = req.fa;
               b_in     = req.fb;
               d_in     = req.dm;
               base_in  = req.base;
               neg_in   = req.neg_n ^ req.neg_d;
               state_in = SclMul;
            end
         end
         SclMul: begin
            quot_in  = a_ff * b_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = SclDiv;
         end
         SclDiv: begin
            if (!diff[16]) begin
               rem_in  = diff[15:0];
               quot_in = {quot_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_sh[15:0];
               quot_in = {quot_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = SclFix;
            end
         end
         SclFix: begin
            done = 1'b1;
            if (sum[34]) begin
               result = '0;
            end else if (|sum[33:16]) begin
               result = '1;
            end else begin
               result = sum[15:0];
            end
            state_in = SclIdle;
         end
         default: begin
            state_in = SclIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SclIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      d_ff    <= d_in;
      base_ff <= base_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

endmodule
